/* design/xkd_pkg.sv */
// shared types, tables and helpers for the xor keystream record decryptor
package xkd_pkg;

	localparam int KEY_BYTES = 16;
	localparam int MAX_PW = 15;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	typedef logic [7:0] char_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PW_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PW_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PW_LEN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VERIFIER  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ALTER_EN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ALTER_KEY = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATE    = 3'd6;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PERM,
		ST_HASH,
		ST_KEYS,
		ST_RUN
	} xkd_state_t;

	localparam logic [15:0] INIT_CODE [MAX_PW] = '{
		16'he1f0, 16'h1d0f, 16'hcc9c, 16'h84c0, 16'h110c, 16'h0e10, 16'hf1ce, 16'h313e,
		16'h1872, 16'he139, 16'hd40f, 16'h84f9, 16'h280c, 16'ha96a, 16'h4ec3
	};

	localparam logic [15:0] XOR_MATRIX [MAX_PW*7] = '{
		16'haefc, 16'h4dd9, 16'h9bb2, 16'h2745, 16'h4e8a, 16'h9d14, 16'h2a09,
		16'h7b61, 16'hf6c2, 16'hfda5, 16'heb6b, 16'hc6f7, 16'h9dcf, 16'h2bbf,
		16'h4563, 16'h8ac6, 16'h05ad, 16'h0b5a, 16'h16b4, 16'h2d68, 16'h5ad0,
		16'h0375, 16'h06ea, 16'h0dd4, 16'h1ba8, 16'h3750, 16'h6ea0, 16'hdd40,
		16'hd849, 16'ha0b3, 16'h5147, 16'ha28e, 16'h553d, 16'haa7a, 16'h44d5,
		16'h6f45, 16'hde8a, 16'had35, 16'h4a4b, 16'h9496, 16'h390d, 16'h721a,
		16'heb23, 16'hc667, 16'h9cef, 16'h29ff, 16'h53fe, 16'ha7fc, 16'h5fd9,
		16'h47d3, 16'h8fa6, 16'h0f6d, 16'h1eda, 16'h3db4, 16'h7b68, 16'hf6d0,
		16'hb861, 16'h60e3, 16'hc1c6, 16'h93ad, 16'h377b, 16'h6ef6, 16'hddec,
		16'h45a0, 16'h8b40, 16'h06a1, 16'h0d42, 16'h1a84, 16'h3508, 16'h6a10,
		16'haa51, 16'h4483, 16'h8906, 16'h022d, 16'h045a, 16'h08b4, 16'h1168,
		16'h76b4, 16'hed68, 16'hcaf1, 16'h85c3, 16'h1ba7, 16'h374e, 16'h6e9c,
		16'h3730, 16'h6e60, 16'hdcc0, 16'ha9a1, 16'h4363, 16'h86c6, 16'h1dad,
		16'h3331, 16'h6662, 16'hccc4, 16'h89a9, 16'h0373, 16'h06e6, 16'h0dcc,
		16'h1021, 16'h2042, 16'h4084, 16'h8108, 16'h1231, 16'h2462, 16'h48c4
	};

	localparam char_t ALTER_PAD [MAX_PW] = '{
		8'h0a, 8'h4e, 8'h51, 8'h6f, 8'h6e, 8'h61, 8'h70, 8'h32,
		8'h33, 8'h71, 8'h5b, 8'h30, 8'h23, 8'h7a, 8'h00
	};

	localparam logic [3:0] ALTER_PERM [MAX_PW] = '{
		4'd9, 4'd4, 4'd1, 4'd3, 4'd14, 4'd11, 4'd6, 4'd0,
		4'd12, 4'd7, 4'd2, 4'd10, 4'd8, 4'd13, 4'd5
	};

	localparam char_t KEY_PAD [KEY_BYTES] = '{
		8'hbb, 8'hff, 8'hff, 8'hba, 8'hff, 8'hff, 8'hb9, 8'h80,
		8'h00, 8'hbe, 8'h0f, 8'h00, 8'hbf, 8'h0f, 8'h00, 8'h00
	};

	// start value of the hash for a password of len characters, len 1..15
	function automatic logic [15:0] init_code_f(input logic [3:0] len);
		logic [3:0] idx;
		idx = len - 4'd1;
		if (len == 4'd0)
			return 16'h0000;
		return INIT_CODE[idx];
	endfunction

	// matrix word for row 0..14 and bit 0..6
	function automatic logic [15:0] xor_word_f(input logic [3:0] row, input logic [2:0] bit_sel);
		logic [6:0] idx;
		idx = 7'(row) * 7'd7 + 7'(bit_sel);
		return XOR_MATRIX[idx];
	endfunction

	function automatic char_t rot_right1_f(input char_t b);
		return {b[0], b[7:1]};
	endfunction

	function automatic char_t rot_left3_f(input char_t b);
		return {b[4:0], b[7:5]};
	endfunction

endpackage

/* design/xor_keystream_record_decrypt_core.sv */
// xor keystream record decryptor: key schedule sequencer and byte datapath
//
//  channel   group                     fields (lsb first)
//  s_axis    s_tvalid/s_tready/tdata   tdata: data_byte[7:0], start_position[23:8]
//                                      tuser: record_start
//  m_axis    m_tvalid/m_tready/tdata   tdata: plain_byte[7:0]; tuser: password_ok
//  cfg       cfg_we/cfg_index/cfg_data one register write per cycle, no read-back
//
// one byte per cycle once the key schedule is built; one register stage to the output
// the key schedule runs load, permute, 15 hash steps and keystream
// after reset and after every register write; s_tready is low during it
// the output register frees in the same cycle it is taken, so m_tready low
// stalls the input only while a result is waiting
module xor_keystream_record_decrypt_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [xkd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [xkd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,   // data_byte, start_position
	input  logic                          s_tuser,   // record_start
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // plain_byte
	output logic                          m_tuser    // password_ok
);
	import xkd_pkg::*;

	// configuration registers
	logic [63:0] pw_low_q;
	logic [55:0] pw_high_q;
	logic [3:0]  pw_len_q;
	logic [15:0] verifier_q;
	logic        alter_en_q;
	logic [3:0]  alter_key_q;
	logic        rotate_q;
	logic        cfg_hit;

	// key schedule
	xkd_state_t state_q, state_d;
	char_t      tmp_q [MAX_PW];
	logic [3:0] len0_q;
	logic [3:0] k_q;
	char_t      pw_q [MAX_PW];
	logic [3:0] len_q;
	logic [3:0] hcnt_q;
	logic [15:0] code_q;
	char_t      ks_q [KEY_BYTES];
	logic       hash_match_q;

	// datapath
	logic [3:0] key_index_q;
	logic       out_valid_q;
	char_t      out_byte_q;
	logic       out_ok_q;

	// load stage
	char_t      raw [MAX_PW];
	char_t      tmp_d [MAX_PW];
	logic [3:0] len0_d;
	logic [3:0] k_d;

	// permute stage
	char_t      pw_d [MAX_PW];
	logic [3:0] len_d;

	// hash step
	logic [15:0] code_base;
	logic [15:0] code_d;
	logic [3:0]  hrow;
	char_t       hchar;

	// keystream
	char_t ks_d [KEY_BYTES];

	// byte path
	logic       s_fire;
	logic       m_fire;
	logic [3:0] use_idx;
	char_t      xb;
	char_t      pb;

	assign cfg_hit = cfg_we && (cfg_index <= CFG_ROTATE);
	assign s_fire  = s_tvalid && s_tready;
	assign m_fire  = out_valid_q && m_tready;
	assign s_tready = (state_q == ST_RUN) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_low_q    <= '0;
			pw_high_q   <= '0;
			pw_len_q    <= 4'd1;
			verifier_q  <= '0;
			alter_en_q  <= 1'b0;
			alter_key_q <= '0;
			rotate_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PW_LOW:    pw_low_q    <= cfg_data;
				CFG_PW_HIGH:   pw_high_q   <= cfg_data[55:0];
				CFG_PW_LEN:    pw_len_q    <= cfg_data[3:0];
				CFG_VERIFIER:  verifier_q  <= cfg_data[15:0];
				CFG_ALTER_EN:  alter_en_q  <= cfg_data[0];
				CFG_ALTER_KEY: alter_key_q <= cfg_data[3:0];
				CFG_ROTATE:    rotate_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// load: split password, find its length, pad and bump for alteration
	always_comb begin
		for (int i = 0; i < 8; i++)
			raw[i] = pw_low_q[8*i +: 8];
		for (int i = 8; i < MAX_PW; i++)
			raw[i] = pw_high_q[8*(i-8) +: 8];
		len0_d = pw_len_q;
		for (int i = MAX_PW - 1; i >= 0; i--)
			if ((4'(i) < pw_len_q) && (raw[i] == 8'h00))
				len0_d = 4'(i);
		k_d = (alter_key_q == 4'd15) ? 4'd0 : alter_key_q;
		for (int i = 0; i < MAX_PW; i++) begin
			if (!alter_en_q || (4'(i) < len0_d))
				tmp_d[i] = raw[i];
			else
				tmp_d[i] = ALTER_PAD[4'(i) - len0_d];
			if (alter_en_q && (4'(i) == k_d))
				tmp_d[i] = tmp_d[i] + 8'd1;
		end
	end

	// permute: rotate through the fixed order starting at k, then recount
	always_comb begin
		logic [4:0] s;
		logic       alive;
		s = '0;
		alive = 1'b1;
		for (int i = 0; i < MAX_PW; i++) begin
			s = 5'(k_q) + 5'(i);
			if (s >= 5'(MAX_PW))
				s = s - 5'(MAX_PW);
			pw_d[i] = alter_en_q ? tmp_q[ALTER_PERM[s[3:0]]] : tmp_q[i];
		end
		len_d = len0_q;
		if (alter_en_q) begin
			alive = 1'b1;
			len_d = 4'(MAX_PW);
			for (int i = 0; i < MAX_PW; i++) begin
				if (alive && (pw_d[i] == 8'h00)) begin
					len_d = 4'(i);
					alive = 1'b0;
				end
			end
		end
	end

	// hash: one password character per cycle against its matrix row
	always_comb begin
		code_base = (hcnt_q == 4'd0) ? init_code_f(len_q) : code_q;
		hrow  = 4'(MAX_PW) - len_q + hcnt_q;
		hchar = pw_q[hcnt_q];
		code_d = code_base;
		if (hcnt_q < len_q)
			for (int b = 0; b < 7; b++)
				if (hchar[b])
					code_d = code_d ^ xor_word_f(hrow, 3'(b));
	end

	always_comb begin
		char_t v;
		char_t kb;
		for (int i = 0; i < KEY_BYTES; i++) begin
			v = KEY_PAD[4'(i) - len_q];
			if ((i < MAX_PW) && (4'(i) < len_q))
				v = pw_q[i];
			kb = (i % 2 == 1) ? verifier_q[15:8] : verifier_q[7:0];
			ks_d[i] = rot_right1_f(v ^ kb);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: state_d = ST_PERM;
			ST_PERM: state_d = ST_HASH;
			ST_HASH: if (hcnt_q == 4'(MAX_PW - 1)) state_d = ST_KEYS;
			ST_KEYS: state_d = ST_RUN;
			ST_RUN:  state_d = ST_RUN;
			default: state_d = ST_LOAD;
		endcase
		if (cfg_hit)
			state_d = ST_LOAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_LOAD;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q       <= '0;
			hash_match_q <= 1'b0;
		end else begin
			if (state_q == ST_HASH)
				hcnt_q <= hcnt_q + 4'd1;
			else
				hcnt_q <= '0;
			if (state_q == ST_KEYS)
				hash_match_q <= (len_q != 4'd0) && (code_q == verifier_q);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			tmp_q  <= tmp_d;
			len0_q <= len0_d;
			k_q    <= k_d;
		end
		if (state_q == ST_PERM) begin
			pw_q  <= pw_d;
			len_q <= len_d;
		end
		if (state_q == ST_HASH)
			code_q <= code_d;
		if (state_q == ST_KEYS)
			ks_q <= ks_d;
	end

	// byte path: nonzero offset at record start reloads the index
	always_comb begin
		use_idx = key_index_q;
		if (s_tuser && (s_tdata[23:8] != 16'h0000))
			use_idx = s_tdata[11:8];
		xb = s_tdata[7:0] ^ ks_q[use_idx];
		pb = rotate_q ? rot_left3_f(xb) : xb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_index_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_hit)
				key_index_q <= '0;
			else if (s_fire)
				key_index_q <= use_idx + 4'd1;
			if (s_fire)
				out_valid_q <= 1'b1;
			else if (m_fire)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			out_byte_q <= pb;
			out_ok_q   <= hash_match_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_ok_q;

endmodule

/* design/xkd_checker.sv */
// port-level checks for the xor keystream record decryptor, bound to the top level
module xkd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic [xkd_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [xkd_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [23:0]                   s_tdata,
	input logic                          s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [7:0]                    m_tdata,
	input logic                          m_tuser
);
	import xkd_pkg::*;

	// a waiting result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result changed while stalled");

	// every accepted item shows a result on the next cycle
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid)
		else $error("accepted item gave no result");

	// input is not taken while a result waits
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input ready with a stalled result");

	// a register write restarts the key schedule
	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_index <= CFG_ROTATE)) |=> !s_tready)
		else $error("input ready right after a register write");

endmodule

bind xor_keystream_record_decrypt_core xkd_checker u_xkd_checker (.*);

/* dv/xkd_decrypt_checker.sv */
// checker for the xor keystream record decryptor: predicts each decrypted byte and compares
`timescale 1ns / 100ps

module xkd_decrypt_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [xkd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [xkd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [23:0]                    s_tdata,   // data_byte, start_position
	input  logic                           s_tuser,   // record_start
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [7:0]                     m_tdata,   // plain_byte
	input  logic                           m_tuser,   // password_ok
	output int                             fail_count,
	output int                             pending,
	output int                             ok_count,
	output logic [15:0]                    hash_word
);
	import xkd_pkg::*;

	typedef struct packed {
		logic [7:0] plain;
		logic       ok;
	} plain_item_t;

	logic [63:0] pw_lo;
	logic [55:0] pw_hi;
	logic [3:0]  pw_len;
	logic [15:0] verifier;
	logic        alter_en;
	logic [3:0]  alter_key;
	logic        rotate_en;

	char_t       keystream [KEY_BYTES];
	logic [3:0]  key_idx;
	logic        pw_match;
	plain_item_t plain_q [$];
	int          byte_no;

	// password hash, match flag and keystream from the current register values
	function automatic void derive_keystream();
		char_t raw [MAX_PW];
		char_t tmp [MAX_PW];
		char_t pw [MAX_PW];
		char_t v;
		char_t kb;
		int len;
		int k;
		logic [15:0] code;
		for (int i = 0; i < 8; i++)
			raw[i] = pw_lo[8*i +: 8];
		for (int i = 8; i < MAX_PW; i++)
			raw[i] = pw_hi[8*(i-8) +: 8];
		len = 0;
		while (len < int'(pw_len) && raw[len] != 8'h00)
			len++;
		if (alter_en) begin
			for (int i = 0; i < MAX_PW; i++)
				tmp[i] = (i < len) ? raw[i] : ALTER_PAD[i-len];
			k = (alter_key >= MAX_PW) ? 0 : int'(alter_key);
			tmp[k] = tmp[k] + 8'd1;
			for (int i = 0; i < MAX_PW; i++) begin
				pw[i] = tmp[ALTER_PERM[k]];
				k = (k == MAX_PW - 1) ? 0 : k + 1;
			end
			len = 0;
			while (len < MAX_PW && pw[len] != 8'h00)
				len++;
		end else begin
			pw = raw;
		end
		code = '0;
		if (len != 0) begin
			code = INIT_CODE[len-1];
			for (int i = 0; i < len; i++)
				for (int b = 0; b < 7; b++)
					if (pw[i][b])
						code ^= XOR_MATRIX[(MAX_PW - len + i) * 7 + b];
		end
		hash_word = code;
		pw_match = (len != 0) && (code == verifier);
		for (int i = 0; i < KEY_BYTES; i++) begin
			v = (i < len) ? pw[i] : KEY_PAD[i-len];
			kb = i[0] ? verifier[15:8] : verifier[7:0];
			v = v ^ kb;
			keystream[i] = {v[0], v[7:1]};
		end
		key_idx = '0;
	endfunction

	function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_PW_LOW:    pw_lo = val;
			CFG_PW_HIGH:   pw_hi = val[55:0];
			CFG_PW_LEN:    pw_len = val[3:0];
			CFG_VERIFIER:  verifier = val[15:0];
			CFG_ALTER_EN:  alter_en = val[0];
			CFG_ALTER_KEY: alter_key = val[3:0];
			CFG_ROTATE:    rotate_en = val[0];
			default:       return;
		endcase
		derive_keystream();
	endfunction

	function automatic plain_item_t decrypt_byte(input logic [7:0] d, input logic rec_start,
			input logic [15:0] pos);
		plain_item_t r;
		logic [7:0] b;
		// a record start at offset zero leaves the index running
		if (rec_start && pos != 16'd0)
			key_idx = pos[3:0];
		b = d ^ keystream[key_idx];
		if (rotate_en)
			b = {b[4:0], b[7:5]};
		key_idx = key_idx + 4'd1;
		r.plain = b;
		r.ok = pw_match;
		return r;
	endfunction

	task automatic report_miss(input string what, input logic [7:0] got, input logic [7:0] want);
		fail_count++;
		$display("mismatch on %s at byte %0d: got %h, want %h", what, byte_no, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		plain_item_t want;
		if (!arst_n) begin
			pw_lo = '0;
			pw_hi = '0;
			pw_len = 4'd1;
			verifier = '0;
			alter_en = 1'b0;
			alter_key = '0;
			rotate_en = 1'b0;
			derive_keystream();
			plain_q.delete();
			fail_count = 0;
			ok_count = 0;
			byte_no = 0;
		end else begin
			if (cfg_we)
				load_register(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				plain_q.push_back(decrypt_byte(s_tdata[7:0], s_tuser, s_tdata[23:8]));
			if (m_tvalid && m_tready) begin
				if (plain_q.size() == 0) begin
					report_miss("unexpected item", m_tdata, 8'h00);
				end else begin
					want = plain_q.pop_front();
					if (m_tdata !== want.plain)
						report_miss("plain_byte", m_tdata, want.plain);
					if (m_tuser !== want.ok)
						report_miss("password_ok", {7'd0, m_tuser}, {7'd0, want.ok});
					if (m_tuser === 1'b1)
						ok_count++;
					byte_no++;
				end
			end
		end
		pending = plain_q.size();
	end

endmodule

/* dv/tb_top.sv */
// testbench top for the xor keystream record decryptor: stimulus, clock, reset and verdict
`timescale 1ns / 100ps

module tb_top;
	import xkd_pkg::*;

	localparam int LIMIT = 200000;
	localparam int RAND_ITEMS = 1400;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [23:0]           s_tdata;   // data_byte, start_position
	logic                  s_tuser;   // record_start
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;   // plain_byte
	logic                  m_tuser;   // password_ok

	int          fail_count;
	int          pending;
	int          ok_count;
	logic [15:0] hash_word;
	int          cycles;
	int          bytes_sent;
	int          reg_writes;
	int          settings;
	logic        quiet;

	xor_keystream_record_decrypt_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	xkd_decrypt_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending),
		.ok_count   (ok_count),
		.hash_word  (hash_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready = quiet || ($urandom_range(99) >= 13);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles, %0d items still expected", cycles, pending);
			$display("** xor_keystream_record_decrypt_core: FAILED **");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic push_byte(input logic [7:0] d, input logic rec_start, input logic [15:0] pos);
		while (!quiet && $urandom_range(99) < 13) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {pos, d};
		s_tuser = rec_start;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	// one register write, then wait for the key schedule to finish
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		reg_writes++;
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 4)
			return 8'h00;
		if (r < 14)
			return 8'($urandom);
		return 8'($urandom_range(8'h7e, 8'h20));
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic shuffle_keys();
		logic [63:0] chars;
		chars = rand_word();
		if ($urandom_range(1)) begin
			for (int i = 0; i < 8; i++)
				chars[8*i +: 8] = pick_char();
			write_reg(CFG_PW_LOW, chars);
		end
		if ($urandom_range(1)) begin
			// top byte stays random, the register only keeps 56 bits
			for (int i = 0; i < 7; i++)
				chars[8*i +: 8] = pick_char();
			write_reg(CFG_PW_HIGH, chars);
		end
		if ($urandom_range(1))
			write_reg(CFG_PW_LEN, rand_word());
		if ($urandom_range(2) == 0)
			write_reg(CFG_ALTER_EN, rand_word());
		if ($urandom_range(2) == 0)
			write_reg(CFG_ALTER_KEY, rand_word());
		if ($urandom_range(2) == 0)
			write_reg(CFG_ROTATE, rand_word());
		if ($urandom_range(9) == 0)
			write_reg(CFG_SPARE, rand_word());
		// verifier last, so about half of the settings get the password's hash as verifier
		if ($urandom_range(1))
			write_reg(CFG_VERIFIER, {48'(rand_word() >> 16), hash_word});
		else
			write_reg(CFG_VERIFIER, rand_word());
		settings++;
	endtask

	initial begin
		int rand_sent;
		int run_len;
		logic [15:0] pos;
		bytes_sent = 0;
		reg_writes = 0;
		settings = 1;
		rand_sent = 0;
		quiet = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: the first character is zero, so the password is empty
		push_byte(8'h00, 1'b0, 16'h0000);
		push_byte(8'hff, 1'b0, 16'h0000);
		push_byte(8'h5a, 1'b1, 16'h0000);
		push_byte(8'ha5, 1'b1, 16'hffff);
		push_byte(8'h3c, 1'b1, 16'h8000);
		push_byte(8'hc3, 1'b0, 16'h1234);
		settle();
		// write past the last register: nothing changes, the index keeps running
		write_reg(CFG_SPARE, 64'hffff_ffff_ffff_ffff);
		push_byte(8'h96, 1'b0, 16'h0000);

		// full fifteen characters, correct verifier, worksheet rotation
		settle();
		write_reg(CFG_PW_LOW, 64'h6867_6665_6463_6261);
		write_reg(CFG_PW_HIGH, 64'h006f_6e6d_6c6b_6a69);
		write_reg(CFG_PW_LEN, 64'd15);
		write_reg(CFG_ROTATE, 64'd1);
		write_reg(CFG_VERIFIER, {48'd0, hash_word});
		settings++;
		push_byte(8'h00, 1'b0, 16'h0000);
		push_byte(8'hff, 1'b0, 16'h0000);
		push_byte(8'h11, 1'b1, 16'h0007);
		push_byte(8'h7e, 1'b0, 16'hffff);

		// zero character inside the length cuts the password short
		settle();
		write_reg(CFG_PW_LOW, 64'h4847_4600_4443_4241);
		write_reg(CFG_PW_LEN, 64'd8);
		write_reg(CFG_ROTATE, 64'd0);
		write_reg(CFG_VERIFIER, 64'h0000_0000_0000_beef);
		settings++;
		push_byte(8'h80, 1'b0, 16'h0000);
		push_byte(8'h01, 1'b1, 16'h000f);
		push_byte(8'h42, 1'b0, 16'h0000);

		// all ones everywhere, alteration with key fifteen
		settle();
		write_reg(CFG_PW_LOW, 64'hffff_ffff_ffff_ffff);
		write_reg(CFG_PW_HIGH, 64'hffff_ffff_ffff_ffff);
		write_reg(CFG_PW_LEN, 64'hffff_ffff_ffff_ffff);
		write_reg(CFG_ALTER_EN, 64'd1);
		write_reg(CFG_ALTER_KEY, 64'd15);
		write_reg(CFG_ROTATE, 64'hffff_ffff_ffff_ffff);
		write_reg(CFG_VERIFIER, {48'hffff_ffff_ffff, hash_word});
		settings++;
		push_byte(8'h00, 1'b0, 16'h0000);
		push_byte(8'hff, 1'b1, 16'h0001);
		push_byte(8'h55, 1'b1, 16'h0000);
		push_byte(8'haa, 1'b0, 16'h0000);

		// length zero under alteration: the password is the pad alone
		settle();
		write_reg(CFG_PW_LEN, 64'd0);
		write_reg(CFG_ALTER_KEY, 64'd14);
		write_reg(CFG_ROTATE, 64'd0);
		write_reg(CFG_VERIFIER, {48'd0, hash_word});
		settings++;
		push_byte(8'h00, 1'b0, 16'h0000);
		push_byte(8'hff, 1'b0, 16'h0000);
		push_byte(8'h24, 1'b1, 16'h000e);
		push_byte(8'hdb, 1'b0, 16'h0000);

		// random records under random settings
		while (rand_sent < RAND_ITEMS) begin
			settle();
			shuffle_keys();
			run_len = $urandom_range(120, 20);
			for (int j = 0; j < run_len && rand_sent < RAND_ITEMS; j++) begin
				quiet = (rand_sent >= 500 && rand_sent < 800);
				case ($urandom_range(2))
					0:       pos = 16'h0000;
					1:       pos = 16'($urandom_range(15));
					default: pos = 16'($urandom);
				endcase
				push_byte(8'($urandom), $urandom_range(15) == 0, pos);
				rand_sent++;
			end
		end
		quiet = 1'b0;

		settle();
		repeat (5) @(negedge clk);
		$display("covered %0d bytes over %0d key settings with %0d register writes",
			bytes_sent, settings, reg_writes);
		$display("%0d bytes came back with the password accepted", ok_count);
		if (fail_count == 0 && pending == 0)
			$display("** xor_keystream_record_decrypt_core: PASSED **");
		else
			$display("** xor_keystream_record_decrypt_core: FAILED **");
		$finish;
	end

endmodule
